// ===== rtl/core/npv_pkg.sv =====
// ----------------------------------------------------------------------------
// npv_pkg: shared definitions for the nearest previous value core
// Data width, default history depth and the running-best record type.
// ----------------------------------------------------------------------------
package npv_pkg;

  localparam int NPV_DATA_W = 32;
  localparam int NPV_DEPTH  = 256;
  localparam int NPV_DIST_W = NPV_DATA_W + 1;

  typedef struct packed {
    logic                         have;
    logic signed [NPV_DATA_W-1:0] value;
    logic [NPV_DIST_W-1:0]        distance;
  } best_t;

endpackage

// ===== rtl/core/npv_hist.sv =====
// ----------------------------------------------------------------------------
// npv_hist: history memory
// One write port and one read port; the read data is registered.
// ----------------------------------------------------------------------------
module npv_hist
  import npv_pkg::*;
#(
  parameter int DEPTH = NPV_DEPTH,
  parameter int AW    = $clog2(DEPTH)
) (
  input  logic                         clk,
  input  logic                         we,
  input  logic [AW-1:0]                waddr,
  input  logic signed [NPV_DATA_W-1:0] wdata,
  input  logic [AW-1:0]                raddr,
  output logic signed [NPV_DATA_W-1:0] rdata
);

  logic signed [NPV_DATA_W-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    rdata <= mem[raddr];
  end

endmodule

// ===== rtl/core/npv_cmp.sv =====
// ----------------------------------------------------------------------------
// npv_cmp: distance and compare unit
// Measures one held value against the sample and updates the running best.
// ----------------------------------------------------------------------------
module npv_cmp
  import npv_pkg::*;
(
  input  logic signed [NPV_DATA_W-1:0] s,
  input  logic signed [NPV_DATA_W-1:0] v,
  input  best_t                        cur,
  output best_t                        nxt
);

  logic signed [NPV_DIST_W-1:0] diff;
  logic [NPV_DIST_W-1:0]        distance;
  logic                         better;

  always_comb begin
    diff     = {v[NPV_DATA_W-1], v} - {s[NPV_DATA_W-1], s};
    distance = diff[NPV_DIST_W-1] ? NPV_DIST_W'(-diff) : NPV_DIST_W'(diff);
    better   = !cur.have || (distance < cur.distance) ||
               ((distance == cur.distance) && (v > cur.value));
    if (better) begin
      nxt.have     = 1'b1;
      nxt.value    = v;
      nxt.distance = distance;
    end else begin
      nxt = cur;
    end
  end

endmodule

// ===== rtl/core/nearest_previous_value_core.sv =====
// ----------------------------------------------------------------------------
// nearest_previous_value_core: closest earlier value of a sample sequence
// A request is taken only while idle; start is ignored while busy, so the last request
// must be done before a new one is taken. The history memory is walked one entry per
// cycle through its single read port and one compare unit; an empty history skips it.
// Reset clears the held count and the sequencer; the memory is not cleared.
// Results are shown for one cycle on done; the receiver cannot stall.
// ----------------------------------------------------------------------------
module nearest_previous_value_core
  import npv_pkg::*;
#(
  parameter int DEPTH = NPV_DEPTH
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         start,
  output logic                         busy,
  input  logic signed [NPV_DATA_W-1:0] sample,
  input  logic                         restart,
  output logic                         done,
  output logic signed [NPV_DATA_W-1:0] nearest,
  output logic                         found,
  output logic                         history_full
);

  localparam int AW = $clog2(DEPTH);
  localparam int CW = $clog2(DEPTH + 1);

  localparam logic [1:0] ST_IDLE  = 2'd0;
  localparam logic [1:0] ST_SCAN  = 2'd1;
  localparam logic [1:0] ST_DRAIN = 2'd2;
  localparam logic [1:0] ST_FIN   = 2'd3;

  logic [1:0]                   state;
  logic [CW-1:0]                held;
  logic [AW-1:0]                idx;
  logic                         pend;
  logic signed [NPV_DATA_W-1:0] s_reg;
  best_t                        best;
  best_t                        best_next;
  logic signed [NPV_DATA_W-1:0] rdata;
  logic                         accept;
  logic                         last_issue;
  logic                         is_full;
  logic [CW-1:0]                held_eff;

  assign busy       = (state != ST_IDLE);
  assign accept     = start && !busy;
  assign last_issue = ((CW'(idx) + CW'(1)) == held);
  assign is_full    = (held == CW'(DEPTH));
  assign held_eff   = restart ? '0 : held;

  npv_hist #(
    .DEPTH (DEPTH),
    .AW    (AW)
  ) u_hist (
    .clk   (clk),
    .we    ((state == ST_FIN) && !is_full),
    .waddr (held[AW-1:0]),
    .wdata (s_reg),
    .raddr (idx),
    .rdata (rdata)
  );

  npv_cmp u_cmp (
    .s   (s_reg),
    .v   (rdata),
    .cur (best),
    .nxt (best_next)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      held  <= '0;
      done  <= 1'b0;
      pend  <= 1'b0;
    end else begin
      done <= 1'b0;
      pend <= (state == ST_SCAN);
      unique case (state)
        ST_IDLE: begin
          if (accept) begin
            held  <= held_eff;
            idx   <= '0;
            state <= (held_eff == '0) ? ST_FIN : ST_SCAN;
          end
        end
        ST_SCAN: begin
          if (last_issue) begin
            state <= ST_DRAIN;
          end else begin
            idx <= idx + AW'(1);
          end
        end
        ST_DRAIN: begin
          state <= ST_FIN;
        end
        ST_FIN: begin
          if (!is_full) begin
            held <= held + CW'(1);
          end
          done  <= 1'b1;
          state <= ST_IDLE;
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s_reg     <= sample;
      best.have <= 1'b0;
    end else if (pend) begin
      best <= best_next;
    end
    if (state == ST_FIN) begin
      nearest      <= best.have ? best.value : '0;
      found        <= best.have;
      history_full <= is_full;
    end
  end

  a_done_after_fin: assert property (@(posedge clk) disable iff (rst)
    done |-> $past(state == ST_FIN))
    else $error("Result shown without a finishing step.");

  a_held_bounded: assert property (@(posedge clk) disable iff (rst)
    held <= CW'(DEPTH))
    else $error("Held count exceeds the history depth.");

  a_full_has_found: assert property (@(posedge clk) disable iff (rst)
    (done && history_full) |-> found)
    else $error("A full history produced no nearest value.");

  a_accept_busy: assert property (@(posedge clk) disable iff (rst)
    accept |=> busy)
    else $error("Core not busy after taking a request.");

endmodule
